@@ design/lrukv_pkg.sv @@
// Shared types and constants of the LRU key/value cache.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package lrukv_pkg;

  localparam int ENTRIES = 16;
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int FUNC_W  = 3;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int ENT_W   = 5;
  localparam int CNT_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET      = 3'd0,
    FUNC_PUT      = 3'd1,
    FUNC_REMOVE   = 3'd2,
    FUNC_CONTAINS = 3'd3,
    FUNC_CLEAR    = 3'd4,
    FUNC_RSTAT    = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_DROP,
    CMD_INSERT,
    CMD_CLEAR
  } cmd_op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t                  op;
    logic                     wr_value;
    logic [RANK_W-1:0]        rank;
    logic signed [KEY_W-1:0]  key;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

  // Handed from each cell to its neighbor along the chain.
  typedef struct packed {
    logic                     hit;
    logic                     claim;
    logic [RANK_W-1:0]        rank;
    logic signed [VAL_W-1:0]  value;
  } cell_link_t;

endpackage

`default_nettype wire

@@ design/lrukv_in_if.sv @@
// Request channel of the LRU key/value cache: valid/ready plus payload.
// Depends on lrukv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrukv_in_if
  import lrukv_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

`default_nettype wire

@@ design/lrukv_out_if.sv @@
// Result channel of the LRU key/value cache: valid/ready plus payload.
// Depends on lrukv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrukv_out_if
  import lrukv_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;
  logic [ENT_W-1:0]        entries_used;
  logic [CNT_W-1:0]        hit_count;
  logic [CNT_W-1:0]        miss_count;

  modport source (output valid, found, read_value, entries_used, hit_count, miss_count,
                  input ready);
  modport sink   (input valid, found, read_value, entries_used, hit_count, miss_count,
                  output ready);
endinterface

`default_nettype wire

@@ design/lrukv_cell.sv @@
// One cache entry: key, value, valid flag and recency rank, plus its link
// in the lookup / free-slot chain. Depends on lrukv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrukv_cell
  import lrukv_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  cell_cmd_t                cmd,
  input  wire signed [KEY_W-1:0]   lookup_key,
  input  cell_link_t               link_i,
  output cell_link_t               link_o,
  output logic                     valid_o,
  output logic                     hit_o
);

  logic                    valid_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] value_r;
  logic [RANK_W-1:0]       rank_r;
  logic                    hit;

  assign hit     = valid_r && (key_r == lookup_key);
  assign hit_o   = hit;
  assign valid_o = valid_r;

  // Keys are unique, so at most one cell along the chain hits.
  always_comb begin
    link_o.hit   = link_i.hit | hit;
    link_o.value = hit ? value_r : link_i.value;
    link_o.rank  = hit ? rank_r : link_i.rank;
    link_o.claim = link_i.claim | ~valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_TOUCH: begin
          if (valid_r) begin
            if (rank_r == cmd.rank) begin
              rank_r <= '0;
              if (cmd.wr_value) begin
                value_r <= cmd.value;
              end
            end else if (rank_r < cmd.rank) begin
              rank_r <= rank_r + 1'b1;
            end
          end
        end
        CMD_DROP: begin
          if (valid_r) begin
            if (rank_r == cmd.rank) begin
              valid_r <= 1'b0;
            end else if (rank_r > cmd.rank) begin
              rank_r <= rank_r - 1'b1;
            end
          end
        end
        CMD_INSERT: begin
          if (valid_r) begin
            rank_r <= rank_r + 1'b1;
          end else if (!link_i.claim) begin
            // first free cell in the chain takes the new entry
            valid_r <= 1'b1;
            key_r   <= cmd.key;
            value_r <= cmd.value;
            rank_r  <= '0;
          end
        end
        CMD_CLEAR: begin
          valid_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/lru_key_value_cache_core.sv @@
// Fully associative LRU key/value cache: a chain of entry cells and the
// sequencer that drives it. Depends on lrukv_pkg, lrukv_in_if, lrukv_out_if,
// lrukv_cell.
// The lookup ripples combinationally through the cell chain; a put that inserts a new
// key passes through an extra insert state. A new request is accepted only once the
// previous result has been loaded into the output register, which waits while the
// result side stalls. Reset (synchronous, active low) clears all valid flags,
// occupancy and counters and sets capacity to 16; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_core
  import lrukv_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  lrukv_in_if.sink          in_ch,
  lrukv_out_if.source       out_ch,
  input  wire               cfg_we,
  input  wire [CAP_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_INS,
    S_RESP
  } state_t;

  state_t                  state_r;
  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    found_r;
  logic signed [VAL_W-1:0] rdval_r;
  logic [OCC_W-1:0]        occ_r;
  logic [CNT_W-1:0]        hit_r;
  logic [CNT_W-1:0]        miss_r;
  logic [CAP_W-1:0]        cap_r;

  logic                    out_valid_r;
  logic                    out_found_r;
  logic signed [VAL_W-1:0] out_rdval_r;
  logic [ENT_W-1:0]        out_used_r;
  logic [CNT_W-1:0]        out_hit_r;
  logic [CNT_W-1:0]        out_miss_r;

  cell_cmd_t               cmd;
  cell_link_t              link [ENTRIES+1];
  logic [ENTRIES-1:0]      valid_vec;
  logic [ENTRIES-1:0]      hit_vec;
  logic [OCC_W-1:0]        cap_eff;
  logic [RANK_W-1:0]       oldest_rank;
  logic                    full;
  logic                    look_hit;
  logic                    out_free;

  assign link[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrukv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .lookup_key (key_r),
      .link_i     (link[g]),
      .link_o     (link[g+1]),
      .valid_o    (valid_vec[g]),
      .hit_o      (hit_vec[g])
    );
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = OCC_W'(1);
    end else if (int'(cap_r) > ENTRIES) begin
      cap_eff = OCC_W'(ENTRIES);
    end else begin
      cap_eff = OCC_W'(cap_r);
    end
  end

  assign full        = (occ_r >= cap_eff);
  assign oldest_rank = RANK_W'(occ_r - 1'b1);
  assign look_hit    = link[ENTRIES].hit;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    cmd          = '0;
    cmd.op       = CMD_NONE;
    cmd.key      = key_r;
    cmd.value    = value_r;
    cmd.rank     = link[ENTRIES].rank;
    if (state_r == S_LOOK) begin
      case (func_r)
        FUNC_GET: begin
          if (look_hit) begin
            cmd.op = CMD_TOUCH;
          end
        end
        FUNC_PUT: begin
          if (look_hit) begin
            cmd.op       = CMD_TOUCH;
            cmd.wr_value = 1'b1;
          end else if (full) begin
            // evict the least recent entry before the insert
            cmd.op   = CMD_DROP;
            cmd.rank = oldest_rank;
          end
        end
        FUNC_REMOVE: begin
          if (look_hit) begin
            cmd.op = CMD_DROP;
          end
        end
        FUNC_CLEAR: begin
          cmd.op = CMD_CLEAR;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_INS) begin
      cmd.op = CMD_INSERT;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.read_value   = out_rdval_r;
  assign out_ch.entries_used = out_used_r;
  assign out_ch.hit_count    = out_hit_r;
  assign out_ch.miss_count   = out_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      hit_r       <= '0;
      miss_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      // a result loaded in S_RESP takes over the output register instead
      if (out_valid_r && out_ch.ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            key_r   <= in_ch.key;
            value_r <= in_ch.value;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          found_r <= 1'b0;
          rdval_r <= '0;
          state_r <= S_RESP;
          case (func_r)
            FUNC_GET: begin
              if (look_hit) begin
                found_r <= 1'b1;
                rdval_r <= link[ENTRIES].value;
                if (hit_r != '1) begin
                  hit_r <= hit_r + 1'b1;
                end
              end else if (miss_r != '1) begin
                miss_r <= miss_r + 1'b1;
              end
            end
            FUNC_PUT: begin
              if (look_hit) begin
                found_r <= 1'b1;
              end else begin
                if (full) begin
                  occ_r <= occ_r - 1'b1;
                end
                state_r <= S_INS;
              end
            end
            FUNC_REMOVE: begin
              if (look_hit) begin
                found_r <= 1'b1;
                occ_r   <= occ_r - 1'b1;
              end
            end
            FUNC_CONTAINS: begin
              found_r <= look_hit;
            end
            FUNC_CLEAR: begin
              occ_r <= '0;
            end
            FUNC_RSTAT: begin
              hit_r  <= '0;
              miss_r <= '0;
            end
            default: begin
            end
          endcase
        end
        S_INS: begin
          occ_r   <= occ_r + 1'b1;
          state_r <= S_RESP;
        end
        S_RESP: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_found_r <= found_r;
            out_rdval_r <= rdval_r;
            out_used_r  <= ENT_W'(occ_r);
            out_hit_r   <= hit_r;
            out_miss_r  <= miss_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy differs from number of valid entries");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> $onehot0(hit_vec))
    else $error("key matched in more than one entry");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> link[ENTRIES].claim)
    else $error("insert without a free entry");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready ##1 !in_ch.ready)
    else $error("new transaction taken before the current one finished");
`endif

endmodule

`default_nettype wire

@@ tb/lru_key_value_cache_core_test.sv @@
// Self-checking testbench for lru_key_value_cache_core: drives cache requests,
// predicts every result with a behavioral LRU cache model, checks each result.
// Depends on lrukv_pkg, lrukv_in_if, lrukv_out_if and the core itself.
`timescale 1ns / 1ps

module lru_key_value_cache_core_test;
  import lrukv_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_OPS      = 100;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } cache_req_t;

  typedef struct {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic [ENT_W-1:0]        entries_used;
    logic [CNT_W-1:0]        hit_count;
    logic [CNT_W-1:0]        miss_count;
  } cache_rsp_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_COIN} rx_pattern_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lrukv_in_if  in_ch ();
  lrukv_out_if out_ch ();

  lru_key_value_cache_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the cache contents and registers
  logic signed [KEY_W-1:0] slot_key [ENTRIES];
  logic signed [VAL_W-1:0] slot_val [ENTRIES];
  bit                      slot_live [ENTRIES];
  int unsigned             slot_age [ENTRIES];
  int unsigned             live_count;
  logic [CNT_W-1:0]        hits;
  logic [CNT_W-1:0]        misses;
  logic [CAP_W-1:0]        cap_reg;

  cache_req_t pending_reqs [$];
  cache_rsp_t expected_rsps [$];
  cache_req_t held_req;
  logic signed [KEY_W-1:0] key_pool [$];
  logic [CAP_W-1:0] phase_caps [12] = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd3,
                                        5'd8, 5'd15, 5'd2, 5'd31, 5'd6, 5'd16};

  int mismatches;
  int rsp_index;
  int burst_left;
  int gap_left;
  int quiet_cycles;
  int mode_left;
  int unsigned rx_tick;
  rx_pattern_t rx_pattern;

  function automatic int find_slot(logic signed [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void promote(int e);
    int unsigned r;
    r = slot_age[e];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[e] = 0;
  endfunction

  function automatic void drop_slot(int e);
    int unsigned r;
    r = slot_age[e];
    slot_live[e] = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
    if (live_count > 0) live_count--;
  endfunction

  // Apply one request to the shadow cache and return the result it must produce.
  function automatic cache_rsp_t predict_access(cache_req_t req);
    cache_rsp_t rsp;
    int e;
    int victim;
    int free_slot;
    int unsigned lim;
    rsp.found = 1'b0;
    rsp.read_value = '0;
    e = find_slot(req.key);
    case (req.func)
      FUNC_GET: begin
        if (e >= 0) begin
          rsp.found = 1'b1;
          rsp.read_value = slot_val[e];
          promote(e);
          if (hits != '1) hits++;
        end else if (misses != '1) begin
          misses++;
        end
      end
      FUNC_PUT: begin
        if (e >= 0) begin
          rsp.found = 1'b1;
          slot_val[e] = req.value;
          promote(e);
        end else begin
          lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
          // Evict exactly one entry, even when capacity sits below occupancy
          if (live_count >= lim) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
            if (victim >= 0) drop_slot(victim);
          end
          free_slot = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (!slot_live[i] && free_slot < 0) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot_live[i]) slot_age[i]++;
            slot_live[free_slot] = 1'b1;
            slot_key[free_slot] = req.key;
            slot_val[free_slot] = req.value;
            slot_age[free_slot] = 0;
            live_count++;
          end
        end
      end
      FUNC_REMOVE: begin
        if (e >= 0) begin
          rsp.found = 1'b1;
          drop_slot(e);
        end
      end
      FUNC_CONTAINS: rsp.found = (e >= 0);
      FUNC_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
        live_count = 0;
      end
      FUNC_RSTAT: begin
        hits = '0;
        misses = '0;
      end
      default: ;
    endcase
    rsp.entries_used = live_count[ENT_W-1:0];
    rsp.hit_count = hits;
    rsp.miss_count = misses;
    return rsp;
  endfunction

  function automatic cache_req_t random_req();
    cache_req_t req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    req.value = $urandom;
    if (roll < 34) req.func = FUNC_GET;
    else if (roll < 64) req.func = FUNC_PUT;
    else if (roll < 75) req.func = FUNC_REMOVE;
    else if (roll < 87) req.func = FUNC_CONTAINS;
    else if (roll < 89) req.func = FUNC_CLEAR;
    else if (roll < 91) req.func = FUNC_RSTAT;
    else if (roll < 93) req.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    else begin
      // Stray key from the whole range, almost always a miss
      req.func = FUNC_W'($urandom_range(FUNC_GET, FUNC_CONTAINS));
      req.key = $urandom;
    end
    return req;
  endfunction

  task automatic queue_req(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k,
                           input logic signed [VAL_W-1:0] v);
    cache_req_t req;
    req.func = f;
    req.key = k;
    req.value = v;
    pending_reqs.push_back(req);
  endtask

  // Sample at the falling edge so the queues and valid are settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    cap_reg = cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int counted;
    int pool_n;
    int unsigned cap_eff;
    logic signed [KEY_W-1:0] base_key;
    logic signed [KEY_W-1:0] pick_key;
    cache_req_t req;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.key = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
    live_count = 0;
    hits = '0;
    misses = '0;
    cap_reg = CAP_RESET;
    mismatches = 0;
    rsp_index = 0;
    burst_left = 0;
    gap_left = 0;
    quiet_cycles = 0;
    mode_left = 0;
    rx_tick = 0;
    rx_pattern = RX_OPEN;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty store, extreme keys and values, update, unused codes
    queue_req(FUNC_GET, 32'sd0, 32'sd0);
    queue_req(FUNC_REMOVE, 32'sh7fff_ffff, 32'sd0);
    queue_req(FUNC_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_req(FUNC_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_req(FUNC_PUT, 32'sd0, 32'sd0);
    queue_req(FUNC_PUT, -32'sd1, -32'sd1);
    queue_req(FUNC_GET, 32'sh8000_0000, 32'sd0);
    queue_req(FUNC_GET, 32'sh7fff_ffff, -32'sd1);
    queue_req(FUNC_CONTAINS, -32'sd1, 32'sd0);
    queue_req(FUNC_CONTAINS, 32'sd5, 32'sd0);
    queue_req(FUNC_PUT, 32'sd0, 32'sd1234);
    queue_req(FUNC_GET, 32'sd0, 32'sd0);
    queue_req(FUNC_SPARE_LO, -32'sd1, -32'sd1);
    queue_req(FUNC_SPARE_HI, 32'sd0, 32'sd0);
    queue_req(FUNC_RSTAT, 32'sd0, 32'sd0);

    // Capacity dropped below occupancy: inserts evict one entry each
    write_capacity(5'd2);
    queue_req(FUNC_PUT, 32'sd11, 32'sd11);
    queue_req(FUNC_PUT, 32'sd12, 32'sd12);
    queue_req(FUNC_REMOVE, 32'sd11, 32'sd0);
    queue_req(FUNC_GET, 32'sd12, 32'sd0);
    queue_req(FUNC_CLEAR, 32'sd0, 32'sd0);
    queue_req(FUNC_GET, 32'sd12, 32'sd0);

    write_capacity(5'd1);
    queue_req(FUNC_PUT, 32'sd21, 32'sd21);
    queue_req(FUNC_PUT, 32'sd22, 32'sd22);
    queue_req(FUNC_GET, 32'sd21, 32'sd0);
    queue_req(FUNC_GET, 32'sd22, 32'sd0);

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      cap_eff = (phase_caps[p] == 0) ? 1 :
                ((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p]);
      // Pool a little larger than capacity keeps both hits and evictions busy
      pool_n = $urandom_range(0, 1) ? cap_eff + $urandom_range(0, 4) : $urandom_range(2, 24);
      base_key = $urandom;
      key_pool.delete();
      repeat (pool_n) begin
        case ($urandom_range(0, 7))
          0: pick_key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
          1: pick_key = base_key ^ (32'h1 << $urandom_range(0, 31));
          default: pick_key = $urandom;
        endcase
        key_pool.push_back(pick_key);
      end
      counted = 0;
      while (counted < PHASE_OPS) begin
        req = random_req();
        pending_reqs.push_back(req);
        if (req.func <= FUNC_RSTAT) counted++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS lru_key_value_cache_core");
    end else begin
      $display("FAIL lru_key_value_cache_core");
    end
    $finish;
  end

  // Request driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) expected_rsps.push_back(predict_access(held_req));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          held_req = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= held_req.func;
          in_ch.key <= held_req.key;
          in_ch.value <= held_req.value;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 19))
              0, 1, 2: gap_left = $urandom_range(10, 40);
              3, 4, 5, 6, 7, 8, 9, 10, 11: gap_left = $urandom_range(1, 4);
              default: gap_left = 0;
            endcase
          end
        end
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    cache_rsp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        rsp_index++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing outstanding: found=%0d value=%0d",
                     rsp_index, out_ch.found, out_ch.read_value);
        end else begin
          want = expected_rsps.pop_front();
          if (out_ch.found !== want.found || out_ch.read_value !== want.read_value ||
              out_ch.entries_used !== want.entries_used ||
              out_ch.hit_count !== want.hit_count || out_ch.miss_count !== want.miss_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d expected found=%0d value=%0d used=%0d hits=%0d misses=%0d",
                       rsp_index, want.found, want.read_value, want.entries_used,
                       want.hit_count, want.miss_count);
              $display("result %0d actual   found=%0d value=%0d used=%0d hits=%0d misses=%0d",
                       rsp_index, out_ch.found, out_ch.read_value, out_ch.entries_used,
                       out_ch.hit_count, out_ch.miss_count);
            end
          end
        end
      end
      if (mode_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      rx_tick++;
      case (rx_pattern)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_LIGHT:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= (rx_tick[1:0] == 2'd0);
        default:     out_ch.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL lru_key_value_cache_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
design/lrukv_pkg.sv
design/lrukv_in_if.sv
design/lrukv_out_if.sv
design/lrukv_cell.sv
design/lru_key_value_cache_core.sv
tb/lru_key_value_cache_core_test.sv
